@@ hw/rtl/cube_vertex_perspective_projector_defines.svh @@
// Assertion macros shared by the projector RTL.
`ifndef CUBE_VERTEX_PERSPECTIVE_PROJECTOR_DEFINES_SVH
`define CUBE_VERTEX_PERSPECTIVE_PROJECTOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CVPP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cvpp check failed");

// Next-cycle implication, checked out of reset.
`define CVPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cvpp check failed");

`endif

@@ hw/rtl/cvpp_pkg.sv @@
// Shared constants, types and helpers of the cube vertex projector.
package cvpp_pkg;

   localparam int ANGLE_BITS = 16;
   localparam int FRAC_BITS  = 8;

   localparam int DIV_STAGES = 32;   // one quotient bit per cell
   localparam int DVS_W      = 18;   // divisor magnitude width

   localparam logic [15:0] SIN_A = 16'd25736;
   localparam logic [15:0] SIN_B = 16'd10512;
   localparam logic [15:0] SIN_C = 16'd1160;
   localparam logic [15:0] HALF_SQRT2_Q16 = 16'd46341;

   localparam logic [15:0] CTP_RESET = 16'd2560;
   localparam logic [15:0] PTO_RESET = 16'd2560;
   localparam logic [9:0]  SCALE_RESET  = 10'd100;
   localparam logic [11:0] OFFSET_RESET = 12'd500;

   localparam logic [1:0] CSR_CAMERA_TO_PLANE = 2'd0;
   localparam logic [1:0] CSR_PLANE_TO_OBJECT = 2'd1;
   localparam logic [1:0] CSR_SCREEN_SCALE    = 2'd2;
   localparam logic [1:0] CSR_SCREEN_OFFSET   = 2'd3;

   // sideband travelling with a vertex through the trig stages
   typedef struct packed {
      logic              valid;
      logic [2:0]        idx;
      logic signed [15:0] h;
      logic [15:0]       r;
   } side_type;

   // state of one divider cell: two divides sharing a divisor
   typedef struct packed {
      logic             valid;
      logic [2:0]       idx;
      logic             behind;
      logic             neg_x;
      logic             neg_y;
      logic [DVS_W-1:0] dvs;
      logic [DVS_W-1:0] rem_x;
      logic [DVS_W-1:0] rem_y;
      logic [31:0]      num_x;
      logic [31:0]      num_y;
   } div_type;

   function automatic logic [15:0] turn16(input logic [15:0] angle);
      logic [63:0] a;
      a = 64'(angle) & ((64'd1 << ANGLE_BITS) - 64'd1);
      if (ANGLE_BITS >= 16) begin
         a = a >> (ANGLE_BITS - 16);
      end else begin
         a = a << (16 - ANGLE_BITS);
      end
      return a[15:0];
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
      if (v > 40'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -40'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

@@ hw/rtl/cvpp_sine.sv @@
// Four-stage pipelined Q14 sine polynomial.
module cvpp_sine (
   input  logic              clock,
   input  logic [15:0]       u,
   output logic signed [15:0] sine
);
   import cvpp_pkg::*;

   logic [14:0] z_in, z1_ff, z2a_ff, z3_ff;
   logic [14:0] zz_in, zz1_ff, zz2_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [10:0] t1_in, t1_ff;
   logic [13:0] t2_in, t2_ff;
   logic [14:0] t3;
   logic [31:0] p0, p1, p2, p3;
   logic signed [15:0] sine_ff;

   always_comb begin
      z_in  = u[14] ? 15'(15'd16384 - 15'(u[13:0])) : 15'(u[13:0]);
      p0    = 32'(z_in) * 32'(z_in);
      zz_in = p0[28:14];
      p1    = 32'(SIN_C) * 32'(zz1_ff);
      t1_in = p1[24:14];
      p2    = 32'(16'(SIN_B - 16'(t1_ff))) * 32'(zz2_ff);
      t2_in = p2[27:14];
      p3    = 32'(16'(SIN_A - 16'(t2_ff))) * 32'(z3_ff);
      t3    = p3[28:14];
   end

   always_ff @(posedge clock) begin
      z1_ff   <= z_in;
      zz1_ff  <= zz_in;
      neg1_ff <= u[15];
      z2a_ff  <= z1_ff;
      zz2_ff  <= zz1_ff;
      t1_ff   <= t1_in;
      neg2_ff <= neg1_ff;
      z3_ff   <= z2a_ff;
      t2_ff   <= t2_in;
      neg3_ff <= neg2_ff;
      sine_ff <= neg3_ff ? -$signed({1'b0, t3}) : $signed({1'b0, t3});
   end

   assign sine = sine_ff;

endmodule

@@ hw/rtl/cvpp_div_cell.sv @@
// One restoring-divider cell: one quotient bit of both divides per cycle.
module cvpp_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  cvpp_pkg::div_type  prev,
   output cvpp_pkg::div_type  next
);
   import cvpp_pkg::*;

   div_type     stage_in, stage_ff;
   logic [DVS_W:0] sh_x, sh_y;
   logic        bit_x, bit_y;

   always_comb begin
      stage_in = prev;
      stage_in.valid = prev.valid && !reset;
      sh_x  = {prev.rem_x, prev.num_x[31]};
      sh_y  = {prev.rem_y, prev.num_y[31]};
      bit_x = sh_x >= {1'b0, prev.dvs};
      bit_y = sh_y >= {1'b0, prev.dvs};
      stage_in.rem_x = bit_x ? DVS_W'(sh_x - {1'b0, prev.dvs}) : DVS_W'(sh_x);
      stage_in.rem_y = bit_y ? DVS_W'(sh_y - {1'b0, prev.dvs}) : DVS_W'(sh_y);
      stage_in.num_x = {prev.num_x[30:0], bit_x};
      stage_in.num_y = {prev.num_y[30:0], bit_y};
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign next = stage_ff;

endmodule

@@ hw/rtl/cube_vertex_perspective_projector.sv @@
// Top level: rotating cube vertex generator with perspective projection.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  request  | start, busy, req_*             | taken when start & !busy
//  response | rsp_valid, rsp_*               | valid per vertex, no stall
//  csr      | csr_we, csr_index, csr_wdata   | write when csr_we, no wait
//
// Each item yields eight vertices, issued one a cycle; busy drops on the
// eighth issue so the next item follows without a gap. A vertex passes a
// 4-stage sine, 3 setup stages, a chain of 32 divider cells (one quotient
// bit each) and 3 screen stages before it is on the result ports.
// Synchronous reset clears control and sets the configuration registers
// to their reset values; the receiver cannot stall.
`include "cube_vertex_perspective_projector_defines.svh"

module cube_vertex_perspective_projector (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [15:0]       req_angle,
   input  logic [15:0]       req_side_length,
   input  logic signed [15:0] req_top_height,
   input  logic signed [15:0] req_bottom_height,
   output logic              rsp_valid,
   output logic [2:0]        rsp_vertex_index,
   output logic signed [15:0] rsp_proj_x,
   output logic signed [15:0] rsp_proj_y,
   output logic signed [15:0] rsp_screen_x,
   output logic signed [15:0] rsp_screen_y,
   output logic              rsp_behind_camera,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import cvpp_pkg::*;

   // sideband copy with its valid cleared in reset
   function automatic side_type side_clear(input side_type s, input logic clr);
      side_type o;
      o = s;
      o.valid = s.valid && !clr;
      return o;
   endfunction

   // configuration registers
   logic [15:0] ctp_ff, pto_ff;
   logic [9:0]  scale_ff;
   logic [11:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctp_ff    <= CTP_RESET;
         pto_ff    <= PTO_RESET;
         scale_ff  <= SCALE_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAMERA_TO_PLANE: ctp_ff    <= csr_wdata;
            CSR_PLANE_TO_OBJECT: pto_ff    <= csr_wdata;
            CSR_SCREEN_SCALE:    scale_ff  <= csr_wdata[9:0];
            CSR_SCREEN_OFFSET:   offset_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   // vertex sequencer: holds the item and issues vertex cnt each cycle while active
   logic        active_ff;
   logic [2:0]  cnt_ff;
   logic [15:0] base_ff, radius_ff;
   logic signed [15:0] top_ff, bot_ff;
   logic        accept;
   logic [31:0] rprod;

   assign busy   = active_ff && (cnt_ff != 3'd7);
   assign accept = start && !busy;
   assign rprod  = 32'(req_side_length) * 32'(HALF_SQRT2_Q16);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= 3'd0;
      end else if (accept) begin
         active_ff <= 1'b1;
         cnt_ff    <= 3'd0;
      end else if (active_ff) begin
         cnt_ff <= cnt_ff + 3'd1;
         if (cnt_ff == 3'd7) begin
            active_ff <= 1'b0;
         end
      end
      if (accept) begin
         base_ff   <= turn16(req_angle);
         radius_ff <= rprod[31:16];
         top_ff    <= req_top_height;
         bot_ff    <= req_bottom_height;
      end
   end

   // angle of this vertex: phi minus k quarter turns
   logic [15:0] u_sin, u_cos;
   logic signed [15:0] sin_v, cos_v;
   side_type    issue;

   assign u_sin = base_ff - {cnt_ff[1:0], 14'd0};
   assign u_cos = u_sin + 16'h4000;

   always_comb begin
      issue.valid = active_ff;
      issue.idx   = cnt_ff;
      issue.h     = cnt_ff[2] ? bot_ff : top_ff;
      issue.r     = radius_ff;
   end

   cvpp_sine u_sin_unit (.clock(clock), .u(u_sin), .sine(sin_v));
   cvpp_sine u_cos_unit (.clock(clock), .u(u_cos), .sine(cos_v));

   // sideband delay matching the sine pipeline
   side_type side_ff [4];
   always_ff @(posedge clock) begin
      side_ff[0] <= side_clear(issue, reset);
      for (int i = 1; i < 4; i++) begin
         side_ff[i] <= side_clear(side_ff[i-1], reset);
      end
   end

   // products with the radius
   side_type side5_ff, side6_ff;
   logic signed [31:0] cr_ff, sr_ff;
   always_ff @(posedge clock) begin
      side5_ff <= side_clear(side_ff[3], reset);
      cr_ff    <= 32'(cos_v) * $signed({16'd0, side_ff[3].r});
      sr_ff    <= 32'(sin_v) * $signed({16'd0, side_ff[3].r});
   end

   // x (negated) and y, divided by 2^14 toward zero
   logic signed [31:0] cr_t, sr_t;
   logic signed [16:0] x_ff, y_ff;
   assign cr_t = cr_ff + (cr_ff < 0 ? 32'sd16383 : 32'sd0);
   assign sr_t = sr_ff + (sr_ff < 0 ? 32'sd16383 : 32'sd0);

   always_ff @(posedge clock) begin
      side6_ff <= side_clear(side5_ff, reset);
      x_ff     <= -17'(cr_t >>> 14);
      y_ff     <= 17'(sr_t >>> 14);
   end

   // divisor and numerator magnitudes; a non-positive divisor is replaced
   logic signed [19:0] dsum;
   logic [16:0] ay, ah;
   div_type     chain [DIV_STAGES+1];

   always_comb begin
      dsum = $signed({4'd0, ctp_ff}) + $signed({4'd0, pto_ff})
             + $signed({{3{x_ff[16]}}, x_ff});
      ay   = y_ff[16] ? 17'(-y_ff) : 17'(y_ff);
      ah   = side6_ff.h[15] ? 17'(-$signed({side6_ff.h[15], side6_ff.h}))
                            : {1'b0, side6_ff.h};
   end

   always_ff @(posedge clock) begin
      chain[0].valid  <= side6_ff.valid && !reset;
      chain[0].idx    <= side6_ff.idx;
      chain[0].behind <= dsum <= 20'sd0;
      chain[0].neg_x  <= !y_ff[16];
      chain[0].neg_y  <= side6_ff.h[15];
      chain[0].dvs    <= (dsum <= 20'sd0) ? DVS_W'(1) : dsum[DVS_W-1:0];
      chain[0].rem_x  <= '0;
      chain[0].rem_y  <= '0;
      chain[0].num_x  <= 32'(ctp_ff) * 32'(ay);
      chain[0].num_y  <= 32'(ctp_ff) * 32'(ah);
   end

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      cvpp_div_cell u_cell (
         .clock(clock), .reset(reset), .prev(chain[g]), .next(chain[g+1])
      );
   end

   // sign and saturate the quotients, zero them behind the camera
   div_type dq;
   logic signed [15:0] px_ff, py_ff, px_in, py_in;
   logic       va_ff, ba_ff, vb_ff, bb_ff;
   logic [2:0] ia_ff, ib_ff;

   assign dq = chain[DIV_STAGES];

   always_comb begin
      if (dq.neg_x) begin
         px_in = (dq.num_x > 32'd32768) ? 16'sh8000 : -$signed(dq.num_x[15:0]);
      end else begin
         px_in = (dq.num_x > 32'd32767) ? 16'sh7FFF : $signed(dq.num_x[15:0]);
      end
      if (dq.neg_y) begin
         py_in = (dq.num_y > 32'd32768) ? 16'sh8000 : -$signed(dq.num_y[15:0]);
      end else begin
         py_in = (dq.num_y > 32'd32767) ? 16'sh7FFF : $signed(dq.num_y[15:0]);
      end
      if (dq.behind) begin
         px_in = '0;
         py_in = '0;
      end
   end

   // pixel stage 1: scale and offset
   logic signed [39:0] vx_ff, vy_ff, off_s, vx_t, vy_t;
   logic signed [15:0] pxb_ff, pyb_ff;
   assign off_s = 40'($signed({1'b0, offset_ff})) <<< FRAC_BITS;

   always_ff @(posedge clock) begin
      va_ff  <= dq.valid && !reset;
      ia_ff  <= dq.idx;
      ba_ff  <= dq.behind;
      px_ff  <= px_in;
      py_ff  <= py_in;
      vb_ff  <= va_ff && !reset;
      ib_ff  <= ia_ff;
      bb_ff  <= ba_ff;
      pxb_ff <= px_ff;
      pyb_ff <= py_ff;
      vx_ff  <= 40'(px_ff) * 40'($signed({1'b0, scale_ff})) + off_s;
      vy_ff  <= 40'(py_ff) * 40'($signed({1'b0, scale_ff})) + off_s;
   end

   // pixel stage 2: divide by 2^FRAC_BITS toward zero, saturate
   assign vx_t = vx_ff + (vx_ff < 0 ? 40'((40'd1 << FRAC_BITS) - 40'd1) : 40'sd0);
   assign vy_t = vy_ff + (vy_ff < 0 ? 40'((40'd1 << FRAC_BITS) - 40'd1) : 40'sd0);

   logic rv_ff;
   always_ff @(posedge clock) begin
      rv_ff             <= vb_ff && !reset;
      rsp_vertex_index  <= ib_ff;
      rsp_last          <= ib_ff == 3'd7;
      rsp_behind_camera <= bb_ff;
      rsp_proj_x        <= pxb_ff;
      rsp_proj_y        <= pyb_ff;
      rsp_screen_x      <= bb_ff ? 16'sd0 : sat16(vx_t >>> FRAC_BITS);
      rsp_screen_y      <= bb_ff ? 16'sd0 : sat16(vy_t >>> FRAC_BITS);
   end
   assign rsp_valid = rv_ff;

   `CVPP_ASSERT_NOW(a_behind_zero, clock, reset, rsp_valid && rsp_behind_camera, rsp_proj_x == 16'sd0 && rsp_proj_y == 16'sd0 && rsp_screen_x == 16'sd0 && rsp_screen_y == 16'sd0)
   `CVPP_ASSERT_NOW(a_last_index, clock, reset, rsp_valid && rsp_last, rsp_vertex_index == 3'd7)
   `CVPP_ASSERT_NEXT(a_accept_first, clock, reset, accept, active_ff && cnt_ff == 3'd0)
   `CVPP_ASSERT_NOW(a_busy_active, clock, reset, busy, active_ff)

endmodule
